// ===== hw/rtl/fst_pkg.sv =====
// Shared types and constants for the Weir-Hill Fst estimator.
package fst_pkg;

  // Fraction bits of the internal fixed-point intermediates.
  localparam int FX = 32;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_FIXED   = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_ZERODEN = 2'd3
  } fst_status_t;

endpackage

// ===== hw/rtl/fst_delay.sv =====
// Fixed-length payload delay line.
module fst_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    taps[0] <= d;
    for (int i = 1; i < DEPTH; i++) begin
      taps[i] <= taps[i-1];
    end
  end

  assign q = taps[DEPTH-1];

endmodule

// ===== hw/rtl/fst_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module fst_div #(
  parameter int NW = 44,
  parameter int DW = 13,
  parameter int QW = 33
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quot
);

  logic [DW-1:0] rr    [QW];
  logic [DW-1:0] dd    [QW];
  logic [QW-1:0] ss    [QW+1];
  logic [DW-1:0] rn    [QW];
  logic [QW-1:0] sn    [QW];
  logic [DW:0]   trial [QW];

  always_comb begin
    for (int i = 0; i < QW; i++) begin
      trial[i] = {rr[i], ss[i][QW-1]};
      if (trial[i] >= {1'b0, dd[i]}) begin
        rn[i] = DW'(trial[i] - {1'b0, dd[i]});
        sn[i] = {ss[i][QW-2:0], 1'b1};
      end else begin
        rn[i] = trial[i][DW-1:0];
        sn[i] = {ss[i][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    rr[0] <= DW'(num[NW-1:QW]);
    ss[0] <= num[QW-1:0];
    dd[0] <= den;
    for (int i = 0; i < QW - 1; i++) begin
      rr[i+1] <= rn[i];
      dd[i+1] <= dd[i];
    end
    for (int i = 0; i < QW; i++) begin
      ss[i+1] <= sn[i];
    end
  end

  assign quot = ss[QW];

endmodule

// ===== hw/rtl/biallelic_fst_estimator.sv =====
// Top level: pipelined Weir-Hill Fst estimator for two populations.
//
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------------
//  site in   | start / busy       | chrom_id, site_position, allele counts
//  result    | done (1-cycle)     | chrom_out, position_out, fst_value, status
//
// One item per cycle; busy stays low. The pipeline length is set by the chain
// of one-bit-per-stage dividers: allele frequencies (33), msg (32), Fst (31).
// Synchronous reset clears the valid pipeline only; payload is not reset.
// The receiver cannot stall; done pulses once per item in input order.
module biallelic_fst_estimator
  import fst_pkg::*;
#(
  parameter int COUNT_WIDTH = 12,
  parameter int FRAC_BITS   = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [7:0]             chrom_id,
  input  logic [30:0]            site_position,
  input  logic [COUNT_WIDTH-1:0] zero_count_a,
  input  logic [COUNT_WIDTH-1:0] one_count_a,
  input  logic [COUNT_WIDTH-1:0] zero_count_b,
  input  logic [COUNT_WIDTH-1:0] one_count_b,
  output logic                   done,
  output logic [7:0]             chrom_out,
  output logic [30:0]            position_out,
  output logic signed [31:0]     fst_value,
  output logic [1:0]             site_status
);

  localparam int CW   = COUNT_WIDTH;
  localparam int NIW  = CW + 1;
  localparam int NNW  = CW + 2;
  localparam int PRW  = 2 * CW + 3;
  localparam int PQ   = FX + 1;
  localparam int MQ   = FX;
  localparam int FQ   = 31;
  localparam int NQ   = CW + 33;
  localparam int SW   = CW + 33;
  localparam int MSW  = CW + 34;
  localparam int T1W  = CW + 33;
  localparam int DNW  = CW + 35;
  localparam int OVW  = DNW + 31 - FRAC_BITS;
  localparam int TA   = 1;
  localparam int TP   = TA + PQ + 1;
  localparam int TN   = TA + 2 + NQ;
  localparam int TF   = TP + 4;
  localparam int TM   = TF + MQ + 1;
  localparam int TI   = TM + 3;
  localparam int TQ   = TI + FQ + 1;
  localparam int LAT  = TQ + 1;

  // stage A
  logic [CW-1:0]  a0, b0;
  logic [NIW-1:0] ni, nj, s0;
  logic [NNW-1:0] nn, nm2;
  fst_status_t    pre;
  fst_status_t    pre_c;
  logic [NIW-1:0] ni_c, nj_c;

  always_comb begin
    ni_c = NIW'(zero_count_a) + NIW'(one_count_a);
    nj_c = NIW'(zero_count_b) + NIW'(one_count_b);
    if ((zero_count_a == '0 && zero_count_b == '0) ||
        (one_count_a == '0 && one_count_b == '0)) begin
      pre_c = ST_FIXED;
    end else if (ni_c == '0 || nj_c == '0) begin
      pre_c = ST_EMPTY;
    end else if ((NNW'(ni_c) + NNW'(nj_c)) <= NNW'(2)) begin
      pre_c = ST_ZERODEN;
    end else begin
      pre_c = ST_VALID;
    end
  end

  always_ff @(posedge clk) begin
    a0  <= zero_count_a;
    b0  <= zero_count_b;
    ni  <= ni_c;
    nj  <= nj_c;
    s0  <= NIW'(zero_count_a) + NIW'(zero_count_b);
    nn  <= NNW'(ni_c) + NNW'(nj_c);
    nm2 <= NNW'(ni_c) + NNW'(nj_c) - NNW'(2);
    pre <= pre_c;
  end

  // stage B
  logic [PRW-1:0] prod;
  logic [NNW-1:0] nn_b;

  always_ff @(posedge clk) begin
    prod <= PRW'({ni, 1'b0}) * PRW'(nj);
    nn_b <= nn;
  end

  // frequencies and nc
  logic [PQ-1:0] p0, p1, pm;
  logic [NQ-1:0] ncq;

  fst_div #(.NW(CW + FX), .DW(NIW), .QW(PQ)) u_div_p0 (
    .clk(clk), .num({a0, {FX{1'b0}}}), .den(ni), .quot(p0));
  fst_div #(.NW(CW + FX), .DW(NIW), .QW(PQ)) u_div_p1 (
    .clk(clk), .num({b0, {FX{1'b0}}}), .den(nj), .quot(p1));
  fst_div #(.NW(NIW + FX), .DW(NNW), .QW(PQ)) u_div_pm (
    .clk(clk), .num({s0, {FX{1'b0}}}), .den(nn), .quot(pm));
  fst_div #(.NW(PRW + FX), .DW(NNW), .QW(NQ)) u_div_nc (
    .clk(clk), .num({prod, {FX{1'b0}}}), .den(nn_b), .quot(ncq));

  // stage C
  logic [PQ-1:0] d0, d1, om0, om1, p0c, p1c;

  always_ff @(posedge clk) begin
    d0  <= (p0 >= pm) ? p0 - pm : pm - p0;
    d1  <= (p1 >= pm) ? p1 - pm : pm - p1;
    om0 <= {1'b1, {FX{1'b0}}} - p0;
    om1 <= {1'b1, {FX{1'b0}}} - p1;
    p0c <= p0;
    p1c <= p1;
  end

  // stage D
  logic [2*PQ-1:0] m_sq0, m_sq1, m_v0, m_v1;
  logic [FX-1:0]   sq0, sq1;
  logic [FX-2:0]   v0, v1;

  assign m_sq0 = d0 * d0;
  assign m_sq1 = d1 * d1;
  assign m_v0  = p0c * om0;
  assign m_v1  = p1c * om1;

  always_ff @(posedge clk) begin
    sq0 <= m_sq0[2*FX-1:FX];
    sq1 <= m_sq1[2*FX-1:FX];
    v0  <= m_v0[2*FX-2:FX];
    v1  <= m_v1[2*FX-2:FX];
  end

  // stage E
  logic [NIW-1:0]    ni_d, nj_d;
  logic [NIW+FX-1:0] ea, eb;
  logic [NIW+FX-2:0] va, vb;

  fst_delay #(.WIDTH(2 * NIW), .DEPTH(TP + 1)) u_dly_n (
    .clk(clk), .d({ni, nj}), .q({ni_d, nj_d}));

  always_ff @(posedge clk) begin
    ea <= ni_d * sq0;
    eb <= nj_d * sq1;
    va <= ni_d * v0;
    vb <= nj_d * v1;
  end

  // stage F
  logic [MSW-1:0] msp;
  logic [SW-1:0]  ssum;
  logic [NNW-1:0] nm2_d;

  fst_delay #(.WIDTH(NNW), .DEPTH(TF - TA)) u_dly_nm2 (
    .clk(clk), .d(nm2), .q(nm2_d));

  always_ff @(posedge clk) begin
    msp  <= MSW'(ea) + MSW'(eb);
    ssum <= SW'(va) + SW'(vb);
  end

  // msg
  logic [MQ-1:0]  msg;
  logic [MSW-1:0] msp_d;
  logic [NQ-1:0]  nc_d;

  fst_div #(.NW(SW), .DW(NNW), .QW(MQ)) u_div_msg (
    .clk(clk), .num(ssum), .den(nm2_d), .quot(msg));
  fst_delay #(.WIDTH(MSW), .DEPTH(TM - TF)) u_dly_msp (
    .clk(clk), .d(msp), .q(msp_d));
  fst_delay #(.WIDTH(NQ), .DEPTH(TM - TN)) u_dly_nc (
    .clk(clk), .d(ncq), .q(nc_d));

  // stage G
  logic [NIW-1:0]  q_m1;
  logic [2*FX-1:0] m_frac;
  logic [T1W-1:0]  t1;
  logic [FX-1:0]   t2, msg_g;
  logic [MSW-1:0]  msp_g;

  assign q_m1   = nc_d[NQ-1:FX] - NIW'(1);
  assign m_frac = nc_d[FX-1:0] * msg;

  always_ff @(posedge clk) begin
    t1    <= q_m1 * msg;
    t2    <= m_frac[2*FX-1:FX];
    msg_g <= msg;
    msp_g <= msp_d;
  end

  // stage H
  logic [DNW-1:0] den_h;
  logic [MSW-1:0] nabs_h;
  logic           neg_h;

  always_ff @(posedge clk) begin
    den_h <= DNW'(msp_g) + DNW'(t1) + DNW'(t2);
    neg_h <= MSW'(msg_g) > msp_g;
    if (MSW'(msg_g) > msp_g) begin
      nabs_h <= MSW'(msg_g) - msp_g;
    end else begin
      nabs_h <= msp_g - MSW'(msg_g);
    end
  end

  // stage I
  logic [DNW-1:0] den_i;
  logic [MSW-1:0] nabs_i;
  logic           neg_i, ovf_i, dz_i;
  logic [OVW-1:0] ov_lhs, ov_rhs;

  assign ov_lhs = OVW'(nabs_h);
  assign ov_rhs = OVW'(den_h) << (31 - FRAC_BITS);

  always_ff @(posedge clk) begin
    den_i  <= den_h;
    nabs_i <= nabs_h;
    neg_i  <= neg_h;
    ovf_i  <= ov_lhs >= ov_rhs;
    dz_i   <= den_h == '0;
  end

  // Fst magnitude
  logic [FQ-1:0] quot;
  logic          neg_q, ovf_q, dz_q;
  logic [1:0]    pre_q;
  logic [7:0]    chrom_q;
  logic [30:0]   pos_q;

  fst_div #(.NW(MSW + FRAC_BITS), .DW(DNW), .QW(FQ)) u_div_fst (
    .clk(clk), .num({nabs_i, {FRAC_BITS{1'b0}}}), .den(den_i), .quot(quot));
  fst_delay #(.WIDTH(3), .DEPTH(TQ - TI)) u_dly_flags (
    .clk(clk), .d({neg_i, ovf_i, dz_i}), .q({neg_q, ovf_q, dz_q}));
  fst_delay #(.WIDTH(2), .DEPTH(TQ - TA)) u_dly_pre (
    .clk(clk), .d(pre), .q(pre_q));
  fst_delay #(.WIDTH(39), .DEPTH(TQ)) u_dly_site (
    .clk(clk), .d({chrom_id, site_position}), .q({chrom_q, pos_q}));

  // output stage
  fst_status_t st_next;
  logic [31:0] fst_next;

  always_comb begin
    st_next  = fst_status_t'(pre_q);
    fst_next = '0;
    if (fst_status_t'(pre_q) == ST_VALID) begin
      if (dz_q) begin
        st_next = ST_ZERODEN;
      end else if (neg_q) begin
        fst_next = ovf_q ? 32'h8000_0000 : 32'd0 - {1'b0, quot};
      end else begin
        fst_next = ovf_q ? 32'h7FFF_FFFF : {1'b0, quot};
      end
    end
  end

  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
    chrom_out    <= chrom_q;
    position_out <= pos_q;
    fst_value    <= fst_next;
    site_status  <= st_next;
  end

  assign done = vld[LAT-1];
  assign busy = 1'b0;

  a_zero_unless_valid: assert property (@(posedge clk) disable iff (rst)
    done && site_status != ST_VALID |-> fst_value == '0)
    else $error("fst_value nonzero on a non-valid site");

  a_done_from_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching item");

endmodule
